// ----- rtl/fspr_pkg.sv -----
// Package with shared types and constants of the framed sensor packet receiver.
`timescale 1ns / 1ps
`default_nettype none
package fspr_pkg;

    localparam int FRAME_LEN  = 24;
    localparam int CHECK_LEN  = 22;
    localparam int STORE_LEN  = FRAME_LEN - 1;
    localparam int NUM_WORDS  = 9;
    localparam int MAG_W      = 15;
    localparam int BATT_W     = 7;
    localparam int POS_W      = 5;

    localparam logic [7:0] HEAD_RESET = 8'h7B;
    localparam logic [7:0] TAIL_RESET = 8'h7D;

    localparam logic [0:0] REG_HEAD = 1'b0;
    localparam logic [0:0] REG_TAIL = 1'b1;

    // Reciprocal of 1000 scaled by 2^26, rounded up; exact for all 16-bit words.
    localparam logic [16:0] DIV_MULT  = 17'd67109;
    localparam int          DIV_SHIFT = 26;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_HEAD = 2'd1,
        STATUS_BAD_TAIL = 2'd2,
        STATUS_BAD_SUM  = 2'd3
    } frame_status_t;

    typedef logic [STORE_LEN-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        frame_status_t                        status;
        logic [7:0]                           stop_flag;
        logic [NUM_WORDS-1:0][MAG_W-1:0]      mags;
        logic [BATT_W-1:0]                    battery;
    } frame_result_t;

endpackage
`default_nettype wire

// ----- rtl/fspr_decode.sv -----
// Frame check and field decode, evaluated on the beat that carries the last byte.
`timescale 1ns / 1ps
`default_nettype none
module fspr_decode (
    input  wire fspr_pkg::frame_bytes_t  frame,
    input  wire [7:0]                    last_byte,
    input  wire [7:0]                    head_byte,
    input  wire [7:0]                    tail_byte,
    input  wire [7:0]                    xor_sum,
    output fspr_pkg::frame_result_t      result
);
    import fspr_pkg::*;

    function automatic logic [MAG_W-1:0] magnitude(input logic [15:0] w);
        logic [15:0] neg;
        begin
            neg = 16'(~w + 16'd1);
            if (!w[15])
            begin
                magnitude = w[MAG_W-1:0];
            end
            else if (w == 16'h8000)
            begin
                magnitude = {MAG_W{1'b1}};
            end
            else
            begin
                magnitude = neg[MAG_W-1:0];
            end
        end
    endfunction

    frame_status_t status;
    logic [15:0]   batt_word;
    logic [32:0]   batt_prod;

    assign batt_word = {frame[20], frame[21]};
    assign batt_prod = 33'(batt_word) * 33'(DIV_MULT);

    always_comb
    begin
        if (frame[0] != head_byte)
        begin
            status = STATUS_BAD_HEAD;
        end
        else if (last_byte != tail_byte)
        begin
            status = STATUS_BAD_TAIL;
        end
        else if (frame[CHECK_LEN] != xor_sum)
        begin
            status = STATUS_BAD_SUM;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        result        = '0;
        result.status = status;
        if (status == STATUS_OK)
        begin
            result.stop_flag = frame[1];
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                result.mags[k] = magnitude({frame[2 + 2 * k], frame[3 + 2 * k]});
            end
            result.battery = batt_prod[DIV_SHIFT +: BATT_W];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/framed_sensor_packet_receiver_unit.sv -----
// Top level of the framed sensor packet receiver.
`timescale 1ns / 1ps
`default_nettype none
// Takes one received byte per beat, one beat per cycle, and groups the bytes into
// back-to-back 24-byte frames counted from reset. Every 24th byte produces one result
// beat in the next cycle, holding the frame status (in tuser) and the decoded fields;
// bad frames carry zeroed fields. s_tready drops only when the last byte of a frame
// arrives while the previous result still waits on the master side, so the input
// sustains one byte per cycle as long as each result is taken by the next frame's last byte.
module framed_sensor_packet_receiver_unit (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire [0:0]    cfg_index,
    input  wire [7:0]    cfg_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // s_tdata: rx_byte[7:0]
    input  wire [7:0]    s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // m_tdata: stop_flag[7:0], x_speed_mag[22:8], y_speed_mag[37:23],
    // z_speed_mag[52:38], x_accel_mag[67:53], y_accel_mag[82:68],
    // z_accel_mag[97:83], x_rate_mag[112:98], y_rate_mag[127:113],
    // z_rate_mag[142:128], battery_volts[149:143], zero fill[151:150]
    output logic [151:0] m_tdata,
    // m_tuser: frame_status[1:0]
    output logic [1:0]   m_tuser
);
    import fspr_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] XOR_END  = POS_W'(CHECK_LEN);

    logic [7:0]       head_reg;
    logic [7:0]       tail_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    frame_bytes_t     frame_reg;
    logic             out_valid_reg;
    logic [151:0]     tdata_reg;
    logic [1:0]       tuser_reg;

    logic             in_beat;
    logic             last_beat;
    frame_result_t    result;

    assign s_tready  = !((pos_reg == LAST_POS) && out_valid_reg && !m_tready);
    assign in_beat   = s_tvalid && s_tready;
    assign last_beat = in_beat && (pos_reg == LAST_POS);

    assign pos_next = (pos_reg == LAST_POS) ? '0 : POS_W'(pos_reg + 1'b1);
    always_comb
    begin
        if (pos_reg == LAST_POS)
        begin
            xor_next = '0;
        end
        else if (pos_reg < XOR_END)
        begin
            xor_next = xor_reg ^ s_tdata;
        end
        else
        begin
            xor_next = xor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= HEAD_RESET;
            tail_reg <= TAIL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEAD: head_reg <= cfg_data;
                REG_TAIL: tail_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            xor_reg <= '0;
        end
        else if (in_beat)
        begin
            pos_reg <= pos_next;
            xor_reg <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_LEN; i++)
        begin
            if (in_beat && (pos_reg == POS_W'(i)))
            begin
                frame_reg[i] <= s_tdata;
            end
        end
    end

    fspr_decode u_decode (
        .frame     (frame_reg),
        .last_byte (s_tdata),
        .head_byte (head_reg),
        .tail_byte (tail_reg),
        .xor_sum   (xor_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (last_beat)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_beat)
        begin
            tdata_reg <= {2'b00, result.battery, result.mags, result.stop_flag};
            tuser_reg <= result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    a_stall_only_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && (pos_reg == LAST_POS)))
        else $error("input stalled outside a pending frame end");

    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_beat |=> out_valid_reg)
        else $error("no result after the last byte of a frame");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position out of range");

    a_xor_clear_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) |-> (xor_reg == '0))
        else $error("checksum not cleared at frame start");

endmodule
`default_nettype wire

// ----- tb/tb_framed_sensor_packet_receiver_unit.sv -----
// Self-checking testbench for the framed sensor packet receiver unit.
`timescale 1ns / 1ps
module tb_framed_sensor_packet_receiver_unit;
    import fspr_pkg::*;

    typedef enum int {
        KIND_GOOD,
        KIND_BAD_HEAD,
        KIND_BAD_TAIL,
        KIND_BAD_SUM,
        KIND_NOISE
    } frame_kind_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 5;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [0:0]    cfg_index = REG_HEAD;
    logic [7:0]    cfg_data = 8'd0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata = 8'd0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [151:0]  m_tdata;
    logic [1:0]    m_tuser;

    logic [7:0]    tx_bytes [$];
    frame_result_t frames_due [$];
    logic [7:0]    frame_buf [FRAME_LEN];
    logic [7:0]    rx_frame [FRAME_LEN];
    logic [4:0]    rx_pos = '0;
    logic [7:0]    rx_sum = '0;
    logic [7:0]    head_cfg = HEAD_RESET;
    logic [7:0]    tail_cfg = TAIL_RESET;
    frame_result_t got_res;
    logic          steady = 1'b0;
    int            stall_left = 0;
    int            quiet = 0;
    int            bytes_queued = 0;
    int            bytes_taken = 0;
    int            mismatches = 0;
    int            settings = 1;
    int            status_seen [4] = '{0, 0, 0, 0};

    framed_sensor_packet_receiver_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic frame_result_t decode_frame();
        frame_result_t r;
        logic [15:0]   w;
        logic [15:0]   neg;
        r = '0;
        if (rx_frame[0] != head_cfg)
            r.status = STATUS_BAD_HEAD;
        else if (rx_frame[FRAME_LEN-1] != tail_cfg)
            r.status = STATUS_BAD_TAIL;
        else if (rx_frame[CHECK_LEN] != rx_sum)
            r.status = STATUS_BAD_SUM;
        else
            r.status = STATUS_OK;
        if (r.status == STATUS_OK)
        begin
            r.stop_flag = rx_frame[1];
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                w = {rx_frame[2 + 2 * k], rx_frame[3 + 2 * k]};
                neg = 16'd0 - w;
                if (w == 16'h8000)
                    r.mags[k] = 15'h7FFF;
                else if (w[15])
                    r.mags[k] = neg[14:0];
                else
                    r.mags[k] = w[14:0];
            end
            w = {rx_frame[20], rx_frame[21]};
            w = w / 16'd1000;
            r.battery = w[BATT_W-1:0];
        end
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Sender side: one beat per cycle from the byte queue, with random gaps, held while s_tready is low.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (tx_bytes.size() > 0 && (steady || $urandom_range(99) >= 15))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= tx_bytes.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver side: short random stalls plus rare long ones that back up the input.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(999) < 4)
        begin
            stall_left = $urandom_range(40, 20);
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || $urandom_range(99) >= 14;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                rx_frame[rx_pos] = s_tdata;
                if (rx_pos < FRAME_LEN - 1)
                begin
                    if (rx_pos < CHECK_LEN)
                        rx_sum = rx_sum ^ s_tdata;
                    rx_pos = rx_pos + 5'd1;
                end
                else
                begin
                    got_res = decode_frame();
                    frames_due.push_back(got_res);
                    status_seen[got_res.status]++;
                    rx_pos = '0;
                    rx_sum = '0;
                end
                bytes_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with status %0d arrived with none due", m_tuser);
                end
                else
                begin
                    got_res = frames_due.pop_front();
                    check_field("frame_status", got_res.status, m_tuser);
                    check_field("stop_flag", got_res.stop_flag, m_tdata[7:0]);
                    for (int k = 0; k < NUM_WORDS; k++)
                        check_field($sformatf("magnitude of word %0d", k),
                                    got_res.mags[k], m_tdata[8 + MAG_W * k +: MAG_W]);
                    check_field("battery_volts", got_res.battery, m_tdata[149:143]);
                    check_field("zero fill", 0, m_tdata[151:150]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("tb_framed_sensor_packet_receiver_unit failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    function automatic logic [15:0] edge_word(input int pick);
        case (pick)
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            4: return 16'h0000;
            5: return 16'h8001;
            6: return 16'h03E7;
            7: return 16'h03E8;
            default: return 16'(($urandom));
        endcase
    endfunction

    task automatic fill_payload();
        logic [15:0] w;
        for (int i = 0; i < FRAME_LEN; i++)
            frame_buf[i] = 8'($urandom);
        for (int i = 2; i <= 20; i += 2)
        begin
            w = edge_word($urandom_range(11));
            frame_buf[i] = w[15:8];
            frame_buf[i + 1] = w[7:0];
        end
    endtask

    task automatic push_frame(input frame_kind_t kind);
        logic [7:0] sum;
        if (kind != KIND_NOISE)
        begin
            frame_buf[0] = head_cfg;
            if (kind == KIND_BAD_HEAD)
                frame_buf[0] = head_cfg ^ 8'($urandom_range(255, 1));
            if (kind != KIND_BAD_HEAD && kind != KIND_BAD_TAIL)
            begin
                sum = '0;
                for (int i = 0; i < CHECK_LEN; i++)
                    sum = sum ^ frame_buf[i];
                frame_buf[CHECK_LEN] = sum;
                if (kind == KIND_BAD_SUM)
                    frame_buf[CHECK_LEN] = sum ^ 8'($urandom_range(255, 1));
                frame_buf[FRAME_LEN-1] = tail_cfg;
            end
            else if (kind == KIND_BAD_TAIL)
                frame_buf[FRAME_LEN-1] = tail_cfg ^ 8'($urandom_range(255, 1));
        end
        for (int i = 0; i < FRAME_LEN; i++)
            tx_bytes.push_back(frame_buf[i]);
        bytes_queued += FRAME_LEN;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || frames_due.size() != 0);
    endtask

    task automatic write_cfg(input logic [7:0] h, input logic [7:0] t);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_HEAD;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= REG_TAIL;
        cfg_data <= t;
        @(posedge clk);
        cfg_we <= 1'b0;
        head_cfg = h;
        tail_cfg = t;
        settings++;
    endtask

    initial
    begin
        int          pick;
        frame_kind_t kind;
        logic [7:0]  v;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1: write_cfg(8'h00, 8'hFF);
                2: write_cfg(8'hFF, 8'h00);
                3: write_cfg(8'($urandom), 8'($urandom));
                4:
                begin
                    v = 8'($urandom);
                    write_cfg(v, v);
                end
                default: ;
            endcase
            if (ph > 0)
                steady <= (ph == 2);

            if (ph == 0)
            begin
                fill_payload();
                frame_buf[1] = 8'hFF;
                for (int k = 0; k < 10; k++)
                begin
                    frame_buf[2 + 2 * k] = 8'hFF;
                    frame_buf[3 + 2 * k] = 8'hFF;
                end
                for (int k = 0; k < 8; k++)
                begin
                    {frame_buf[2 + 2 * k], frame_buf[3 + 2 * k]} = edge_word(k);
                end
                push_frame(KIND_GOOD);
                for (int i = 1; i < CHECK_LEN; i++)
                    frame_buf[i] = 8'h00;
                {frame_buf[20], frame_buf[21]} = 16'h03E7;
                push_frame(KIND_GOOD);
                fill_payload();
                push_frame(KIND_BAD_HEAD);
                fill_payload();
                push_frame(KIND_BAD_TAIL);
                fill_payload();
                push_frame(KIND_BAD_SUM);
            end

            for (int f = 0; f < 16; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 72)
                    kind = KIND_GOOD;
                else if (pick < 79)
                    kind = KIND_BAD_HEAD;
                else if (pick < 86)
                    kind = KIND_BAD_TAIL;
                else if (pick < 93)
                    kind = KIND_BAD_SUM;
                else
                    kind = KIND_NOISE;
                fill_payload();
                push_frame(kind);
                // Let the pipeline run dry once in the middle of a phase.
                if (ph == 3 && f == 7)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        $display("Sent %0d bytes under %0d head/tail settings; checked %0d ok, %0d bad head,",
                 bytes_taken, settings, status_seen[STATUS_OK], status_seen[STATUS_BAD_HEAD]);
        $display("%0d bad tail and %0d bad checksum frames, %0d mismatches.",
                 status_seen[STATUS_BAD_TAIL], status_seen[STATUS_BAD_SUM], mismatches);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("tb_framed_sensor_packet_receiver_unit passed");
        else
            $display("tb_framed_sensor_packet_receiver_unit failed");
        $finish;
    end

endmodule
